// ===== sv/spl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spl_pkg
// Shared constants, codes and controller/datapath types of the sample player.
// ----------------------------------------------------------------------------
package spl_pkg;

   localparam int MEMORY_WORDS  = 65536;
   localparam int MAX_CHANNELS  = 8;
   localparam int FRACTION_BITS = 16;

   localparam int MEM_AW      = $clog2(MEMORY_WORDS);
   localparam int OUT_CAP     = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;
   localparam int SAMPLE_W    = 16;
   localparam int FRAME_W     = 18;
   localparam int POS_W       = FRACTION_BITS + FRAME_W;
   localparam int ADV_W       = POS_W + 2;
   localparam int STEP_W      = 21;
   localparam int CC_W        = 4;
   localparam int CH_W        = 3;
   localparam int BASE_W      = (FRAME_W - 1) + CC_W;
   localparam int ADDR_CALC_W = BASE_W + 1;
   localparam int PROD_W      = SAMPLE_W + 1 + FRACTION_BITS;
   localparam int ACC_W       = FRACTION_BITS + FRAME_W;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = STEP_W;

   typedef enum logic [1:0] {
      ACT_LOAD = 2'd0,
      ACT_TICK = 2'd1,
      ACT_JUMP = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_END_FRAME     = 3'd0,
      CSR_LOOP_START    = 3'd1,
      CSR_LOOP_END      = 3'd2,
      CSR_LOOP_ENABLE   = 3'd3,
      CSR_RATE_STEP     = 3'd4,
      CSR_WIDE_SAMPLES  = 3'd5,
      CSR_CHANNEL_COUNT = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic ld_item;
      logic ram_wr;
      logic jump;
      logic start;
      logic base;
      logic rd0;
      logic rd1;
      logic cap1;
      logic mul;
      logic emit;
      logic adv_add;
      logic adv_wrap;
      logic adv_sat;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic       stopped;
      logic       chans_zero;
      logic       last_ch;
      logic       out_free;
   } status_type;

endpackage

// ===== sv/spl_channels.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spl_channels
// Request, response and register write channels of the sample player.
// ----------------------------------------------------------------------------
interface spl_req_if;
   import spl_pkg::*;

   logic          valid;
   logic          ready;
   logic [1:0]    action;
   logic [15:0]   word_address;
   logic [15:0]   sample_word;
   logic [15:0]   jump_frame;

   modport source (output valid, action, word_address, sample_word, jump_frame,
                   input ready);
   modport sink (input valid, action, word_address, sample_word, jump_frame,
                 output ready);
endinterface

interface spl_rsp_if;
   import spl_pkg::*;

   logic                 valid;
   logic                 ready;
   logic [CH_W-1:0]      channel;
   logic signed [15:0]   level;
   logic                 last;

   modport source (output valid, channel, level, last, input ready);
   modport sink (input valid, channel, level, last, output ready);
endinterface

interface spl_csr_if;
   import spl_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/spl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spl_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module spl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     write_enable,
   input  logic [$clog2(DEPTH)-1:0] address,
   input  logic [WIDTH-1:0]         write_data,
   output logic [WIDTH-1:0]         read_data
);

   logic [WIDTH-1:0] storage_ff [DEPTH];
   logic [WIDTH-1:0] read_data_ff;

   always_ff @(posedge clock) begin
      if (write_enable) begin
         storage_ff[address] <= write_data;
      end
      read_data_ff <= storage_ff[address];
   end

   assign read_data = read_data_ff;

endmodule

// ===== sv/spl_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spl_ctrl
// Sequencer of the sample player: dispatches words, steps through channels
// and runs the position update.
// ----------------------------------------------------------------------------
module spl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  spl_pkg::status_type status,
   output spl_pkg::cmd_type    cmd
);
   import spl_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DISPATCH,
      S_START,
      S_BASE,
      S_RD0,
      S_RD1,
      S_CAP1,
      S_MUL,
      S_EMIT,
      S_ADV_ADD,
      S_ADV_WRAP,
      S_ADV_SAT
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) state_ff <= S_DISPATCH;
            end
            S_DISPATCH: begin
               if (status.action == ACT_TICK) state_ff <= S_START;
               else state_ff <= S_IDLE;
            end
            S_START: state_ff <= S_BASE;
            S_BASE: begin
               priority if (status.chans_zero) begin
                  state_ff <= status.stopped ? S_IDLE : S_ADV_ADD;
               end else if (status.stopped) begin
                  state_ff <= S_EMIT;
               end else begin
                  state_ff <= S_RD0;
               end
            end
            S_RD0:  state_ff <= S_RD1;
            S_RD1:  state_ff <= S_CAP1;
            S_CAP1: state_ff <= S_MUL;
            S_MUL:  state_ff <= S_EMIT;
            S_EMIT: begin
               if (status.out_free) begin
                  priority if (status.last_ch) begin
                     state_ff <= status.stopped ? S_IDLE : S_ADV_ADD;
                  end else if (status.stopped) begin
                     state_ff <= S_EMIT;
                  end else begin
                     state_ff <= S_RD0;
                  end
               end
            end
            S_ADV_ADD:  state_ff <= S_ADV_WRAP;
            S_ADV_WRAP: state_ff <= S_ADV_SAT;
            S_ADV_SAT:  state_ff <= S_IDLE;
            default:    state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd          = '0;
      cmd.ld_item  = (state_ff == S_IDLE) && req_valid;
      cmd.ram_wr   = (state_ff == S_DISPATCH) && (status.action == ACT_LOAD);
      cmd.jump     = (state_ff == S_DISPATCH) && (status.action == ACT_JUMP);
      cmd.start    = (state_ff == S_START);
      cmd.base     = (state_ff == S_BASE);
      cmd.rd0      = (state_ff == S_RD0);
      cmd.rd1      = (state_ff == S_RD1);
      cmd.cap1     = (state_ff == S_CAP1);
      cmd.mul      = (state_ff == S_MUL);
      cmd.emit     = (state_ff == S_EMIT) && status.out_free;
      cmd.adv_add  = (state_ff == S_ADV_ADD);
      cmd.adv_wrap = (state_ff == S_ADV_WRAP);
      cmd.adv_sat  = (state_ff == S_ADV_SAT);
   end

   a_accept_dispatch: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_DISPATCH)
      else $error("accepted word not dispatched");

   a_emit_holds: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_EMIT && !status.out_free |=> state_ff == S_EMIT)
      else $error("result dropped while output busy");

   a_advance_after_last: assert property (@(posedge clock) disable iff (reset)
      cmd.emit && status.last_ch && !status.stopped |=> state_ff == S_ADV_ADD)
      else $error("position not advanced after final channel");

endmodule

// ===== sv/spl_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spl_datapath
// Registers, sample memory, address arithmetic, interpolation and position
// update of the sample player.
// ----------------------------------------------------------------------------
module spl_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [1:0]           action,
   input  logic [15:0]          word_address,
   input  logic [15:0]          sample_word,
   input  logic [15:0]          jump_frame,
   spl_csr_if.sink              csr_port,
   spl_rsp_if.source            rsp_port,
   input  spl_pkg::cmd_type     cmd,
   output spl_pkg::status_type  status
);
   import spl_pkg::*;

   function automatic logic [SAMPLE_W-1:0] to_level(input logic [SAMPLE_W-1:0] w,
                                                   input logic wide);
      to_level = wide ? w : {~w[7], w[6:0], 8'h00};
   endfunction

   // configuration
   logic [15:0]        end_frame_ff;
   logic [15:0]        loop_start_ff;
   logic [15:0]        loop_end_ff;
   logic               loop_enable_ff;
   logic [STEP_W-1:0]  rate_step_ff;
   logic               wide_samples_ff;
   logic [CC_W-1:0]    channel_count_ff;

   // accepted word
   logic [1:0]         action_ff;
   logic [15:0]        word_address_ff;
   logic [15:0]        sample_word_ff;
   logic [15:0]        jump_frame_ff;

   // tick working state
   logic [POS_W-1:0]          pos_ff;
   logic                      stopped_ff;
   logic [FRAME_W-1:0]        frame_ff;
   logic [FRACTION_BITS-1:0]  frac_ff;
   logic [CC_W-1:0]           chans_ff;
   logic [CH_W-1:0]           ch_ff;
   logic [BASE_W-1:0]         base_ff;
   logic                      oob0_ff;
   logic                      oob1_ff;
   logic [SAMPLE_W-1:0]       s0_ff;
   logic [SAMPLE_W-1:0]       s1_ff;
   logic [PROD_W-1:0]         prod_ff;
   logic [ADV_W-1:0]          adv_ff;

   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [CH_W-1:0]           rsp_channel_ff;
   logic [SAMPLE_W-1:0]       rsp_level_ff;
   logic                      rsp_last_ff;

   logic [ADDR_CALC_W-1:0]    addr0;
   logic [ADDR_CALC_W-1:0]    addr1;
   logic                      frame_is_m1;
   logic [MEM_AW-1:0]         ram_address;
   logic [SAMPLE_W-1:0]       ram_rdata;
   logic [SAMPLE_W-1:0]       rd_level;
   logic                      pos_stopped;
   logic signed [SAMPLE_W:0]  diff;
   logic signed [PROD_W:0]    prod_full;
   logic [ACC_W-1:0]          acc;
   logic                      last_ch;
   logic                      step_pos;
   logic [FRAME_W-1:0]        loop_len;
   logic [ADV_W-1:0]          loop_len_sh;
   logic [ADV_W-1:0]          loop_end_pos;
   logic [ADV_W-1:0]          loop_start_pos;
   logic [ADV_W-1:0]          pos_max_ext;
   logic [ADV_W-1:0]          pos_min_ext;
   logic                      csr_write;

   // address arithmetic
   assign frame_is_m1 = (frame_ff == '1);
   assign addr0 = {1'b0, base_ff} + ADDR_CALC_W'(ch_ff);
   assign addr1 = frame_is_m1 ? ADDR_CALC_W'(ch_ff)
                : {1'b0, base_ff} + ADDR_CALC_W'(channel_count_ff) + ADDR_CALC_W'(ch_ff);

   always_comb begin
      priority if (cmd.ram_wr) ram_address = word_address_ff[MEM_AW-1:0];
      else if (cmd.rd0)        ram_address = MEM_AW'(addr0);
      else                     ram_address = MEM_AW'(addr1);
   end

   spl_ram #(
      .WIDTH (SAMPLE_W),
      .DEPTH (MEMORY_WORDS)
   ) u_sample_ram (
      .clock        (clock),
      .write_enable (cmd.ram_wr),
      .address      (ram_address),
      .write_data   (sample_word_ff),
      .read_data    (ram_rdata)
   );

   assign rd_level = to_level(ram_rdata, wide_samples_ff);

   // interpolation
   assign diff      = $signed({s1_ff[SAMPLE_W-1], s1_ff}) - $signed({s0_ff[SAMPLE_W-1], s0_ff});
   assign prod_full = diff * $signed({1'b0, frac_ff});
   assign acc = {{(ACC_W-SAMPLE_W-FRACTION_BITS){s0_ff[SAMPLE_W-1]}}, s0_ff,
                 {FRACTION_BITS{1'b0}}}
              + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff}
              + (ACC_W'(1) << (FRACTION_BITS - 1));

   assign pos_stopped = ($signed(pos_ff) > $signed({2'b00, end_frame_ff, {FRACTION_BITS{1'b0}}}))
                      || (pos_ff[POS_W-1] && !loop_enable_ff);

   assign last_ch = ((CC_W'(ch_ff) + CC_W'(1)) == chans_ff);

   // position update terms
   assign step_pos       = !rate_step_ff[STEP_W-1] && (rate_step_ff != '0);
   assign loop_len       = {2'b00, loop_end_ff} - {2'b00, loop_start_ff} + FRAME_W'(1);
   assign loop_len_sh    = {{(ADV_W-FRAME_W-FRACTION_BITS){loop_len[FRAME_W-1]}}, loop_len,
                            {FRACTION_BITS{1'b0}}};
   assign loop_end_pos   = ADV_W'({loop_end_ff, {FRACTION_BITS{1'b0}}});
   assign loop_start_pos = ADV_W'({loop_start_ff, {FRACTION_BITS{1'b0}}});
   assign pos_max_ext    = {{(ADV_W-POS_W+1){1'b0}}, {(POS_W-1){1'b1}}};
   assign pos_min_ext    = {{(ADV_W-POS_W+1){1'b1}}, {(POS_W-1){1'b0}}};

   assign csr_write       = csr_port.valid && csr_port.ready;
   assign csr_port.ready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         end_frame_ff     <= '0;
         loop_start_ff    <= '0;
         loop_end_ff      <= '0;
         loop_enable_ff   <= 1'b0;
         rate_step_ff     <= STEP_W'(1 << FRACTION_BITS);
         wide_samples_ff  <= 1'b1;
         channel_count_ff <= CC_W'(1);
      end else if (csr_write) begin
         unique case (csr_port.index)
            CSR_END_FRAME:     end_frame_ff     <= csr_port.data[15:0];
            CSR_LOOP_START:    loop_start_ff    <= csr_port.data[15:0];
            CSR_LOOP_END:      loop_end_ff      <= csr_port.data[15:0];
            CSR_LOOP_ENABLE:   loop_enable_ff   <= csr_port.data[0];
            CSR_RATE_STEP:     rate_step_ff     <= csr_port.data[STEP_W-1:0];
            CSR_WIDE_SAMPLES:  wide_samples_ff  <= csr_port.data[0];
            CSR_CHANNEL_COUNT: channel_count_ff <= csr_port.data[CC_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.ld_item) begin
         action_ff       <= action;
         word_address_ff <= word_address;
         sample_word_ff  <= sample_word;
         jump_frame_ff   <= jump_frame;
      end
      if (cmd.start) begin
         frame_ff <= pos_ff[POS_W-1:FRACTION_BITS];
         frac_ff  <= pos_ff[FRACTION_BITS-1:0];
         chans_ff <= (channel_count_ff > CC_W'(OUT_CAP)) ? CC_W'(OUT_CAP) : channel_count_ff;
      end
      if (cmd.base) begin
         base_ff <= frame_ff[FRAME_W-2:0] * channel_count_ff;
      end
      if (cmd.rd0) begin
         oob0_ff <= frame_ff[FRAME_W-1] || (32'(addr0) >= 32'(MEMORY_WORDS));
      end
      if (cmd.rd1) begin
         oob1_ff <= (frame_ff[FRAME_W-1] && !frame_is_m1)
                    || (32'(addr1) >= 32'(MEMORY_WORDS));
         s0_ff   <= oob0_ff ? '0 : rd_level;
      end
      if (cmd.cap1) begin
         s1_ff <= oob1_ff ? '0 : rd_level;
      end
      if (cmd.mul) begin
         prod_ff <= prod_full[PROD_W-1:0];
      end
      if (cmd.adv_add) begin
         adv_ff <= {{(ADV_W-POS_W){pos_ff[POS_W-1]}}, pos_ff}
                 + {{(ADV_W-STEP_W){rate_step_ff[STEP_W-1]}}, rate_step_ff};
      end
      if (cmd.adv_wrap && loop_enable_ff) begin
         if (step_pos) begin
            if ($signed(adv_ff) > $signed(loop_end_pos)) adv_ff <= adv_ff - loop_len_sh;
         end else begin
            if ($signed(adv_ff) < $signed(loop_start_pos)) adv_ff <= loop_end_pos;
         end
      end
      if (cmd.emit) begin
         rsp_channel_ff <= ch_ff;
         rsp_level_ff   <= stopped_ff ? '0 : acc[FRACTION_BITS+SAMPLE_W-1:FRACTION_BITS];
         rsp_last_ff    <= last_ch;
      end
   end

   always_comb begin
      priority if (cmd.emit)   rsp_valid_in = 1'b1;
      else if (rsp_port.ready) rsp_valid_in = 1'b0;
      else                     rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         stopped_ff   <= 1'b0;
         ch_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         priority if (cmd.jump) begin
            pos_ff <= {2'b00, jump_frame_ff, {FRACTION_BITS{1'b0}}};
         end else if (cmd.adv_sat) begin
            priority if ($signed(adv_ff) > $signed(pos_max_ext)) pos_ff <= pos_max_ext[POS_W-1:0];
            else if ($signed(adv_ff) < $signed(pos_min_ext))     pos_ff <= pos_min_ext[POS_W-1:0];
            else                                                 pos_ff <= adv_ff[POS_W-1:0];
         end
         if (cmd.start) begin
            stopped_ff <= pos_stopped;
            ch_ff      <= '0;
         end else if (cmd.emit) begin
            ch_ff <= ch_ff + CH_W'(1);
         end
      end
   end

   assign status.action     = action_ff;
   assign status.stopped    = stopped_ff;
   assign status.chans_zero = (chans_ff == '0);
   assign status.last_ch    = last_ch;
   assign status.out_free   = !rsp_valid_ff || rsp_port.ready;

   assign rsp_port.valid   = rsp_valid_ff;
   assign rsp_port.channel = rsp_channel_ff;
   assign rsp_port.level   = rsp_level_ff;
   assign rsp_port.last    = rsp_last_ff;

   a_emit_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_valid_ff || rsp_port.ready))
      else $error("result overwrote a waiting result");

   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("result valid without emit");

endmodule

// ===== sv/sample_player_linear_interp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sample_player_linear_interp
// Multichannel looping sample player with linear interpolation.
// ----------------------------------------------------------------------------
// A tick word waits whenever the result channel stalls. While playing, each
// channel reads two frames one after another through the single-port sample
// RAM, then passes the one interpolation multiplier, and the position update
// runs as three steps (add, loop wrap, saturate) after the final channel.
// Once stopped, each channel is emitted as zero without a read and the
// position is not updated. The sample memory has no clearing pass; no word is
// taken until the previous one is finished. Register writes are taken at any
// time and must only be issued while the player is idle.
module sample_player_linear_interp (
   input  logic       clock,
   input  logic       reset,
   spl_req_if.sink    req_port,
   spl_rsp_if.source  rsp_port,
   spl_csr_if.sink    csr_port
);
   import spl_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       req_ready;

   assign req_port.ready = req_ready;

   spl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_port.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   spl_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .action       (req_port.action),
      .word_address (req_port.word_address),
      .sample_word  (req_port.sample_word),
      .jump_frame   (req_port.jump_frame),
      .csr_port     (csr_port),
      .rsp_port     (rsp_port),
      .cmd          (cmd),
      .status       (status)
   );

endmodule
